@@ hw/rtl/deq_pkg.sv @@
// shared types and constants for the double-ended queue
// no dependencies; used by deq_cell, double_ended_queue and the testbench
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    ActPushFront = 2'd0,
    ActPushRear  = 2'd1,
    ActPopFront  = 2'd2,
    ActPopRear   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic    en;
    action_e act;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// top level of the double-ended queue: row of deq_cell slots and result register
// depends on deq_pkg and deq_cell
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of signed 32-bit words, deq_pkg::Depth entries deep.
// The entries sit in a row of cells with the front in cell 0; the occupied
// cells always form an unbroken run from cell 0, so fullness is the last
// cell's occupancy bit and emptiness is cell 0's. A front push shifts the
// whole row one cell rearwards and drops the word into cell 0, a front pop
// shifts it one cell frontwards, and rear operations touch only the cell at
// the end of the run. Every transfer in gives exactly one transfer out:
// popped_value_o (-1 for a pop on an empty deque, 0 for any push), status_o
// (0 ok, 1 pop on empty, 2 push on full) and now_empty_o. Rate: one item per
// clock cycle while the output side does not stall, with a registered result;
// the row shifts once per cycle, so one item per cycle is what it
// takes. The result register holds a finished result while the next input
// is taken, and in_stall_o rises only when that register is full and the
// output side stalls. Rejected items leave the row untouched. No clearing
// pass is needed after reset: only the occupancy bits are reset.

module double_ended_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic signed [31:0]            value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [31:0]                 popped_value_o,
  output logic [1:0]                         status_o,
  output logic                               now_empty_o
);

  localparam int unsigned Depth = deq_pkg::Depth;
  localparam int unsigned Dw    = deq_pkg::DataWidth;

  // row wiring
  logic [Dw-1:0]      cell_data  [Depth];
  logic [Depth-1:0]   cell_valid;
  logic [Depth-1:0]   cell_last;
  logic [Dw-1:0]      left_data  [Depth];
  logic [Depth-1:0]   left_valid;
  logic [Dw-1:0]      right_data [Depth];
  logic [Depth-1:0]   right_valid;

  deq_pkg::cell_cmd_t cmd;
  deq_pkg::action_e   act;
  logic               in_accept;
  logic               is_full, is_empty;
  logic [Dw-1:0]      rear_data;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [Dw-1:0]      popped_q, popped_d;
  deq_pkg::status_e   status_q, status_d;
  logic               empty_q, empty_d;

  assign act        = deq_pkg::action_e'(action_i);
  // the result register frees up in the same cycle it is taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_full  = cell_valid[Depth-1];
  assign is_empty = !cell_valid[0];

  // neighbour links; cell 0 sees the incoming word on its left, the last
  // cell sees an empty slot on its right
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (i == 0) begin
        left_data[i]  = value_i;
        left_valid[i] = 1'b1;
      end else begin
        left_data[i]  = cell_data[i-1];
        left_valid[i] = cell_valid[i-1];
      end
      if (i == Depth - 1) begin
        right_data[i]  = '0;
        right_valid[i] = 1'b0;
      end else begin
        right_data[i]  = cell_data[i+1];
        right_valid[i] = cell_valid[i+1];
      end
    end
  end

  // rear word: unless the deque is empty, exactly one cell flags itself as the end of the run
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < Depth; i++) begin
      rear_data = rear_data | (cell_data[i] & {Dw{cell_last[i]}});
    end
  end

  // command to the row and the result of this transfer
  always_comb begin
    cmd.act  = act;
    cmd.en   = 1'b0;
    popped_d = '0;
    status_d = deq_pkg::StOk;
    empty_d  = 1'b0;
    unique case (act) inside
      deq_pkg::ActPushFront, deq_pkg::ActPushRear: begin
        // a push never leaves the deque empty
        if (is_full) status_d = deq_pkg::StFull;
        else         cmd.en   = in_accept;
      end
      default: begin
        // after a pop the deque is empty exactly when cell 1 is vacant
        empty_d = !cell_valid[1];
        if (is_empty) begin
          popped_d = '1;
          status_d = deq_pkg::StEmpty;
        end else begin
          cmd.en   = in_accept;
          popped_d = (act == deq_pkg::ActPopFront) ? cell_data[0] : rear_data;
        end
      end
    endcase
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .push_value_i  (value_i),
      .left_data_i   (left_data[g]),
      .left_valid_i  (left_valid[g]),
      .right_data_i  (right_data[g]),
      .right_valid_i (right_valid[g]),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .is_last_o     (cell_last[g])
    );
  end

  // result valid: set on an input transfer, cleared once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload loads only on an input transfer, so a stalled result holds
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      empty_q  <= empty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign now_empty_o    = empty_q;

endmodule

`default_nettype wire

@@ hw/rtl/deq_cell.sv @@
// one slot of the shifting deque row: a data word and an occupancy bit
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire deq_pkg::cell_cmd_t            cmd_i,
  input  wire logic [deq_pkg::DataWidth-1:0] push_value_i,
  input  wire logic [deq_pkg::DataWidth-1:0] left_data_i,
  input  wire logic                          left_valid_i,
  input  wire logic [deq_pkg::DataWidth-1:0] right_data_i,
  input  wire logic                          right_valid_i,
  output logic      [deq_pkg::DataWidth-1:0] data_o,
  output logic                               valid_o,
  output logic                               is_last_o
);

  logic [deq_pkg::DataWidth-1:0] data_q, data_d;
  logic                          valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.en) begin
      unique case (cmd_i.act)
        deq_pkg::ActPushFront: begin
          data_d  = left_data_i;
          valid_d = left_valid_i;
        end
        deq_pkg::ActPushRear: begin
          // first free slot takes the word
          if (!valid_q && left_valid_i) begin
            data_d  = push_value_i;
            valid_d = 1'b1;
          end
        end
        deq_pkg::ActPopFront: begin
          data_d  = right_data_i;
          valid_d = right_valid_i;
        end
        default: begin
          if (valid_q && !right_valid_i) valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign is_last_o = valid_q && !right_valid_i;

endmodule

`default_nettype wire

@@ tb/sv/tb_double_ended_queue.sv @@
// self-checking testbench for the double_ended_queue block: directed table then random traffic
// depends on deq_pkg for the action and status codes, and on double_ended_queue itself
`timescale 1ns / 1ps

module tb_double_ended_queue;

  import deq_pkg::*;

  localparam int unsigned HeadWidth    = $clog2(Depth);
  localparam int unsigned NumRandom    = 1950;
  localparam int unsigned QuietTail    = 200;  // last items run with no idling at all
  localparam int unsigned HoldAt       = 300;  // random item that triggers the long output hold
  localparam int unsigned DrainAt      = 900;  // random item before which the sender waits
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned TailCycles   = 4;    // extra wait after the last result, as margin
  localparam int unsigned IdleLimit    = 2000; // cycles with no transfer before giving up
  localparam logic signed [DataWidth-1:0] EmptyPopWord = -32'sd1;
  localparam logic signed [DataWidth-1:0] WordMax      = 32'sh7fff_ffff;
  localparam logic signed [DataWidth-1:0] WordMin      = 32'sh8000_0000;

  typedef struct {
    logic signed [DataWidth-1:0] popped;
    status_e                     status;
    logic                        empty;
  } deque_result_t;

  // one line of the directed table; fixed rows carry their own expected result
  typedef struct {
    action_e                     act;
    logic signed [DataWidth-1:0] word;
    bit                          fixed;
    deque_result_t               res;
  } stim_row_t;

  // dut signals, all inputs known from time zero
  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [1:0]                  action_i = ActPushRear;
  logic signed [DataWidth-1:0] value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [DataWidth-1:0] popped_value_o;
  logic [1:0]                  status_o;
  logic                        now_empty_o;

  // predictor state: a ring of words, front slot and live count
  logic signed [DataWidth-1:0] ring_store [Depth];
  logic [HeadWidth-1:0]        ring_head  = '0;
  logic [HeadWidth:0]          ring_count = '0;
  int unsigned                 peak_fill  = 0;

  deque_result_t pending_results [$];
  stim_row_t     dir_rows [$];

  int unsigned fail_count   = 0;
  int unsigned checked      = 0;
  int unsigned empty_pops   = 0;
  int unsigned full_pushes  = 0;
  int unsigned idle_cycles  = 0;

  // sender-to-receiver requests; each side owns its own variable
  bit          quiet_phase = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_ack    = 1'b0;
  int unsigned burst_left  = 0;

  double_ended_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .now_empty_o    (now_empty_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ring slot that lies off entries behind the front one
  function automatic logic [HeadWidth-1:0] ring_slot(int unsigned off);
    int unsigned s;
    s = 32'(ring_head) + off;
    if (s >= Depth) s -= Depth;
    return s[HeadWidth-1:0];
  endfunction

  // advance the predictor by one accepted item and return the result it gives
  function automatic deque_result_t predict_deque(action_e act, logic signed [DataWidth-1:0] word);
    deque_result_t r;
    logic [HeadWidth-1:0] slot;
    r.popped = '0;
    r.status = StOk;
    case (act) inside
      ActPushFront, ActPushRear: begin
        if (ring_count >= Depth) begin
          // full: word dropped, nothing moves
          r.status = StFull;
        end else begin
          if (act == ActPushFront) begin
            ring_head = (ring_head == 0) ? HeadWidth'(Depth - 1) : ring_head - 1'b1;
            slot = ring_head;
          end else begin
            slot = ring_slot(32'(ring_count));
          end
          ring_store[slot] = word;
          ring_count++;
        end
      end
      default: begin
        if (ring_count == 0) begin
          r.popped = EmptyPopWord;
          r.status = StEmpty;
        end else begin
          if (act == ActPopFront) begin
            r.popped  = ring_store[ring_head];
            ring_head = ring_slot(1);
          end else begin
            r.popped = ring_store[ring_slot(32'(ring_count) - 1)];
          end
          ring_count--;
          if (ring_count == 0) ring_head = '0;
        end
      end
    endcase
    r.empty = (ring_count == 0);
    if (32'(ring_count) > peak_fill) peak_fill = 32'(ring_count);
    return r;
  endfunction

  function automatic void add_row(action_e act, logic signed [DataWidth-1:0] word, bit fixed,
                                  logic signed [DataWidth-1:0] popped = '0,
                                  status_e st = StOk, logic empty = 1'b0);
    stim_row_t row;
    row.act        = act;
    row.word       = word;
    row.fixed      = fixed;
    row.res.popped = popped;
    row.res.status = st;
    row.res.empty  = empty;
    dir_rows.push_back(row);
  endfunction

  // a word for a push: mostly random, now and then an extreme
  function automatic logic signed [DataWidth-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return WordMax;
      1:       return WordMin;
      2:       return '0;
      3:       return EmptyPopWord;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and return at the edge where its transfer happens;
  // valid is only lowered when a gap or a drain is wanted
  task automatic send_item(action_e act, logic signed [DataWidth-1:0] word,
                           int unsigned gap, bit drain);
    if (drain || gap != 0) begin
      in_valid_i <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stimulus: directed table, then random segments, then the closing wait
  initial begin
    deque_result_t res;
    action_e       act;
    int unsigned   sent;
    int unsigned   seg_left;
    int unsigned   push_pct;
    int unsigned   gap;
    bit            gappy;

    // after reset both pops see an empty deque, and a first push is plain
    add_row(ActPopFront, '0, 1'b1, EmptyPopWord, StEmpty, 1'b1);
    add_row(ActPopRear, 32'sh1234_5678, 1'b1, EmptyPopWord, StEmpty, 1'b1);
    add_row(ActPushFront, WordMax, 1'b1, '0, StOk, 1'b0);
    add_row(ActPushRear, WordMin, 1'b0);
    add_row(ActPopFront, '0, 1'b0);
    add_row(ActPopRear, EmptyPopWord, 1'b0);
    // fill to the brim from both ends, with front pushes wrapping the ring
    for (int i = 0; i < Depth; i++) begin
      add_row((i % 2) ? ActPushRear : ActPushFront,
              (i == 0) ? EmptyPopWord : (i == 1) ? '0 : (i == 2) ? 32'shaaaa_aaaa :
              (i == 3) ? 32'sh5555_5555 : (32'sd1 <<< i), 1'b0);
    end
    // pushes on a full deque are turned away
    add_row(ActPushFront, WordMin, 1'b1, '0, StFull, 1'b0);
    add_row(ActPushRear, WordMax, 1'b1, '0, StFull, 1'b0);
    add_row(ActPopRear, '0, 1'b0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      send_item(dir_rows[i].act, dir_rows[i].word, gap, 1'b0);
      res = predict_deque(dir_rows[i].act, dir_rows[i].word);
      if (dir_rows[i].fixed) res = dir_rows[i].res;
      pending_results.push_back(res);
    end

    // random part: segments that lean towards filling, draining or neither
    sent     = 0;
    seg_left = 0;
    push_pct = 50;
    gappy    = 1'b1;
    while (sent < NumRandom) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
        gappy = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      if ($urandom_range(0, 99) < push_pct) begin
        act = $urandom_range(0, 1) ? ActPushRear : ActPushFront;
      end else begin
        act = $urandom_range(0, 1) ? ActPopRear : ActPopFront;
      end
      if (sent == NumRandom - QuietTail) quiet_phase <= 1'b1;
      if (sent == HoldAt) hold_req <= ~hold_req;
      gap = (gappy && sent < NumRandom - QuietTail && $urandom_range(0, 3) == 0) ?
            $urandom_range(1, 10) : 0;
      send_item(act, pick_word(), gap, sent == DrainAt);
      pending_results.push_back(predict_deque(act, value_i));
      sent++;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("checked %0d results: %0d pops on empty, %0d pushes on full, peak fill %0d of %0d",
             checked, empty_pops, full_pushes, peak_fill, Depth);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // output side: compare each transfer out, and drive the stall in bursts
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no item pending: popped_value %0d status %0d",
               popped_value_o, status_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.status == StEmpty) empty_pops++;
        if (want.status == StFull) full_pushes++;
        if (popped_value_o !== want.popped) begin
          $error("popped_value: expected %0d, got %0d", want.popped, popped_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (now_empty_o !== want.empty) begin
          $error("now_empty: expected %0d, got %0d", want.empty, now_empty_o);
          fail_count++;
        end
      end
    end

    if (hold_req != hold_ack) begin
      // long hold-off so the result register fills and the input stalls
      hold_ack    <= hold_req;
      out_stall_i <= 1'b1;
      burst_left  <= HoldCycles;
    end else if (burst_left > 1) begin
      burst_left <= burst_left - 1;
    end else if (quiet_phase) begin
      out_stall_i <= 1'b0;
      burst_left  <= 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      burst_left  <= $urandom_range(1, 10);
    end else begin
      out_stall_i <= 1'b0;
      burst_left  <= $urandom_range(1, 40);
    end
  end

  // watchdog: give up when neither side has moved a transfer for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
